// ===== rtl/core/mips1_instruction_predecoder_macros.svh =====
// assertion macros used by the predecoder checker
`ifndef MIPS1_INSTRUCTION_PREDECODER_MACROS_SVH
`define MIPS1_INSTRUCTION_PREDECODER_MACROS_SVH

// implication checked every clock edge outside reset
`define MIPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("predecoder implication check failed");

// plain invariant checked every clock edge outside reset
`define MIPD_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("predecoder invariant check failed");

`endif

// ===== rtl/core/mipd_pkg.sv =====
// types and encoding constants for the mips-i instruction predecoder
package mipd_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_COP2    = 6'd18;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LWL     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_LWR     = 6'd38;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SWL     = 6'd42;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_SWR     = 6'd46;
    localparam logic [5:0] OP_LWC2    = 6'd50;
    localparam logic [5:0] OP_SWC2    = 6'd58;

    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_BREAK   = 6'd13;

    localparam logic [4:0] REG_ZERO   = 5'd0;
    localparam logic [4:0] REG_RA     = 5'd31;
    localparam logic [4:0] COPMV_MF   = 5'd0;
    localparam logic [4:0] COPMV_CF   = 5'd2;

    // one bit per known-valid code, bit index is the code
    localparam logic [63:0] VALID_OPS = 64'h0F0F4F7F_000FFFFE;
    localparam logic [63:0] VALID_FNS = 64'h00000CFF_0F0F33DD;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic is_branch;
        logic is_unconditional;
        logic is_direct;
        logic is_call;
        logic is_return;
        logic is_load;
        logic is_store;
        logic has_load_delay;
        logic ends_block;
        logic is_valid;
        logic is_jump;
        logic is_unaligned;
    } flags_t;

endpackage

// ===== rtl/core/mipd_decode.sv =====
// opcode and funct classification of one instruction word
module mipd_decode (
    input  logic [31:0]    instruction,
    output mipd_pkg::flags_t flags
);
    import mipd_pkg::*;

    logic [5:0] op;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [5:0] fn;
    logic       special;
    logic       jreg;
    logic       direct;
    logic       load;
    logic       store;

    assign op = instruction[31:26];
    assign rs = instruction[25:21];
    assign rt = instruction[20:16];
    assign fn = instruction[5:0];

    assign special = (op == OP_SPECIAL);
    assign jreg    = special && (fn == FN_JR || fn == FN_JALR);
    assign direct  = (op >= OP_REGIMM) && (op <= OP_BGTZ);

    assign load  = op == OP_LB || op == OP_LH || op == OP_LW || op == OP_LBU ||
                   op == OP_LHU || op == OP_LWL || op == OP_LWR || op == OP_LWC2;
    assign store = op == OP_SB || op == OP_SH || op == OP_SW || op == OP_SWL ||
                   op == OP_SWR || op == OP_SWC2;

    always_comb
    begin
        flags.is_branch        = direct || jreg;
        flags.is_unconditional = op == OP_REGIMM || op == OP_J || op == OP_JAL ||
                                 (op == OP_BEQ && rs == REG_ZERO && rt == REG_ZERO) || jreg;
        flags.is_direct        = direct;
        flags.is_call          = (special && fn == FN_JALR) || op == OP_JAL;
        flags.is_return        = jreg && rs == REG_RA;
        flags.is_load          = load;
        flags.is_store         = store;
        // lwc2 has no integer load delay, cop moves from cop0/cop2 do
        flags.has_load_delay   = (load && op != OP_LWC2) ||
                                 ((op == OP_COP0 || op == OP_COP2) &&
                                  (rs == COPMV_MF || rs == COPMV_CF));
        flags.ends_block       = special && (fn == FN_SYSCALL || fn == FN_BREAK);
        flags.is_valid         = special ? VALID_FNS[fn] : VALID_OPS[op];
        flags.is_jump          = op == OP_J || op == OP_JAL;
        flags.is_unaligned     = op == OP_LWL || op == OP_LWR || op == OP_SWL ||
                                 op == OP_SWR;
    end

endmodule

// ===== rtl/core/mipd_addr.sv =====
// branch target and load/store effective address arithmetic
module mipd_addr (
    input  logic [31:0]      instruction,
    input  logic [31:0]      next_pc,
    input  logic [31:0]      base_value,
    input  mipd_pkg::flags_t flags,
    output logic [31:0]      branch_target,
    output logic [31:0]      effective_address
);
    import mipd_pkg::*;

    logic [31:0] imm_ext;
    logic [31:0] ea_sum;

    assign imm_ext = {{16{instruction[15]}}, instruction[15:0]};
    assign ea_sum  = base_value + imm_ext;

    always_comb
    begin
        if (flags.is_jump)
            branch_target = {next_pc[31:28], instruction[25:0], 2'b00};
        else if (flags.is_direct)
            branch_target = next_pc + {imm_ext[29:0], 2'b00};
        else
            branch_target = next_pc;

        if (!(flags.is_load || flags.is_store))
            effective_address = '0;
        else if (flags.is_unaligned)
            effective_address = {ea_sum[31:2], 2'b00};
        else
            effective_address = ea_sum;
    end

endmodule

// ===== rtl/core/mips1_instruction_predecoder.sv =====
// top level of the mips-i instruction predecoder: input and result registers
// a taken beat passes the input rank and then the result rank, where it shows with done
// throughput: one instruction per cycle, set by the single decode pass between two register ranks
// busy never rises: the result rank cannot be held off, so no beat waits
// reset clears the valid bits of both ranks; payload registers are not reset
module mips1_instruction_predecoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] instruction,
    input  logic [31:0] pc,
    input  logic [31:0] base_value,
    output logic        done,
    output logic        is_branch,
    output logic        is_unconditional,
    output logic        is_direct,
    output logic        is_call,
    output logic        is_return,
    output logic        is_load,
    output logic        is_store,
    output logic        has_load_delay,
    output logic        ends_block,
    output logic        is_valid,
    output logic [31:0] branch_target,
    output logic [31:0] effective_address
);
    import mipd_pkg::*;

    logic        in_valid_reg;
    logic [31:0] instr_reg;
    logic [31:0] next_pc_reg;
    logic [31:0] base_reg;
    logic        done_reg;
    flags_t      flags_reg;
    logic [31:0] target_reg;
    logic [31:0] ea_reg;

    flags_t      flags_next;
    logic [31:0] target_next;
    logic [31:0] ea_next;

    assign busy = 1'b0;

    mipd_decode u_decode (
        .instruction (instr_reg),
        .flags       (flags_next)
    );

    mipd_addr u_addr (
        .instruction       (instr_reg),
        .next_pc           (next_pc_reg),
        .base_value        (base_reg),
        .flags             (flags_next),
        .branch_target     (target_next),
        .effective_address (ea_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            instr_reg   <= instruction;
            next_pc_reg <= pc + PC_STEP;
            base_reg    <= base_value;
        end
        if (in_valid_reg)
        begin
            flags_reg  <= flags_next;
            target_reg <= target_next;
            ea_reg     <= ea_next;
        end
    end

    assign done              = done_reg;
    assign is_branch         = flags_reg.is_branch;
    assign is_unconditional  = flags_reg.is_unconditional;
    assign is_direct         = flags_reg.is_direct;
    assign is_call           = flags_reg.is_call;
    assign is_return         = flags_reg.is_return;
    assign is_load           = flags_reg.is_load;
    assign is_store          = flags_reg.is_store;
    assign has_load_delay    = flags_reg.has_load_delay;
    assign ends_block        = flags_reg.ends_block;
    assign is_valid          = flags_reg.is_valid;
    assign branch_target     = target_reg;
    assign effective_address = ea_reg;

endmodule

// ===== rtl/core/mipd_checker.sv =====
// port-level checker for the predecoder, bound to the top level
`include "mips1_instruction_predecoder_macros.svh"

module mipd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        is_branch,
    input logic        is_unconditional,
    input logic        is_direct,
    input logic        is_load,
    input logic        is_store,
    input logic        is_return,
    input logic [31:0] effective_address
);

    // every accepted beat comes out with done
    `MIPD_ASSERT_IMP(a_beat_out, start && !busy, ##2 done)
    // no result without an earlier accepted beat
    `MIPD_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 2))
    // address is zero for anything that is not a memory access
    `MIPD_ASSERT_IMP(a_ea_zero, done && !is_load && !is_store, effective_address == 32'd0)
    // a return is an unconditional register-indirect branch
    `MIPD_ASSERT_IMP(a_return_class, done && is_return,
                     is_branch && is_unconditional && !is_direct)

endmodule

bind mips1_instruction_predecoder mipd_checker u_mipd_checker (.*);

// ===== tb/tb_top.sv =====
// testbench for the mips-i instruction predecoder: directed and random beats, self-checking
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mipd_pkg::*;

    localparam logic [5:0] OP_BNE  = 6'd5;
    localparam logic [5:0] OP_BLEZ = 6'd6;
    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_UNKNOWN = 6'd1;
    localparam logic [4:0] COPMV_MT = 5'd4;

    // codes known to be valid, bit index is the opcode or funct
    localparam logic [63:0] KNOWN_OPCODES = 64'h0F0F4F7F_000FFFFE;
    localparam logic [63:0] KNOWN_FUNCTS  = 64'h00000CFF_0F0F33DD;

    localparam int RANDOM_BEATS = 500;
    localparam int CALM_TAIL    = 100;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int DRAIN_LIMIT  = 1000;

    typedef struct packed {
        logic        is_branch;
        logic        is_unconditional;
        logic        is_direct;
        logic        is_call;
        logic        is_return;
        logic        is_load;
        logic        is_store;
        logic        has_load_delay;
        logic        ends_block;
        logic        is_valid;
        logic [31:0] branch_target;
        logic [31:0] effective_address;
    } decode_t;

    class predecode_board;
        decode_t pending_decodes[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function decode_t decode_word(logic [31:0] word, logic [31:0] pc_in,
                                      logic [31:0] base);
            decode_t    d;
            logic [5:0] op;
            logic [5:0] fn;
            logic [4:0] rs;
            logic [4:0] rt;
            logic [31:0] imm;
            logic [31:0] next_pc;
            logic       special;
            logic       reg_jump;
            logic       direct_br;
            op = word[31:26];
            fn = word[5:0];
            rs = word[25:21];
            rt = word[20:16];
            imm = {{16{word[15]}}, word[15:0]};
            next_pc = pc_in + 32'd4;
            special = (op == OP_SPECIAL);
            reg_jump = special && (fn == FN_JR || fn == FN_JALR);
            direct_br = (op >= OP_REGIMM && op <= OP_BGTZ);
            d.is_branch = direct_br || reg_jump;
            d.is_unconditional = op == OP_REGIMM || op == OP_J || op == OP_JAL ||
                (op == OP_BEQ && rs == REG_ZERO && rt == REG_ZERO) || reg_jump;
            d.is_direct = direct_br;
            d.is_call = (special && fn == FN_JALR) || op == OP_JAL;
            d.is_return = reg_jump && rs == REG_RA;
            d.is_load = op inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWL, OP_LWR,
                                   OP_LWC2};
            d.is_store = op inside {OP_SB, OP_SH, OP_SW, OP_SWL, OP_SWR, OP_SWC2};
            d.has_load_delay = (d.is_load && op != OP_LWC2) ||
                ((op == OP_COP0 || op == OP_COP2) && (rs == COPMV_MF || rs == COPMV_CF));
            d.ends_block = special && (fn == FN_SYSCALL || fn == FN_BREAK);
            d.is_valid = special ? KNOWN_FUNCTS[fn] : KNOWN_OPCODES[op];
            if (op == OP_J || op == OP_JAL)
                d.branch_target = {next_pc[31:28], word[25:0], 2'b00};
            else if (direct_br)
                d.branch_target = next_pc + (imm << 2);
            else
                d.branch_target = next_pc;
            d.effective_address = 32'd0;
            if (d.is_load || d.is_store)
            begin
                d.effective_address = base + imm;
                // partial-word ops address the aligned word
                if (op inside {OP_LWL, OP_LWR, OP_SWL, OP_SWR})
                    d.effective_address[1:0] = 2'b00;
            end
            return d;
        endfunction

        function void note(logic [31:0] word, logic [31:0] pc_in, logic [31:0] base);
            pending_decodes.push_back(decode_word(word, pc_in, base));
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check(decode_t got);
            decode_t want;
            if (pending_decodes.size() == 0)
            begin
                $error("result beat with no instruction outstanding");
                errors++;
                return;
            end
            want = pending_decodes.pop_front();
            compare("is_branch", want.is_branch, got.is_branch);
            compare("is_unconditional", want.is_unconditional, got.is_unconditional);
            compare("is_direct", want.is_direct, got.is_direct);
            compare("is_call", want.is_call, got.is_call);
            compare("is_return", want.is_return, got.is_return);
            compare("is_load", want.is_load, got.is_load);
            compare("is_store", want.is_store, got.is_store);
            compare("has_load_delay", want.has_load_delay, got.has_load_delay);
            compare("ends_block", want.ends_block, got.ends_block);
            compare("is_valid", want.is_valid, got.is_valid);
            compare("branch_target", want.branch_target, got.branch_target);
            compare("effective_address", want.effective_address, got.effective_address);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] base_value;
    logic        done;
    logic        is_branch;
    logic        is_unconditional;
    logic        is_direct;
    logic        is_call;
    logic        is_return;
    logic        is_load;
    logic        is_store;
    logic        has_load_delay;
    logic        ends_block;
    logic        is_valid;
    logic [31:0] branch_target;
    logic [31:0] effective_address;

    predecode_board board = new();
    int cycles;
    bit calm;

    mips1_instruction_predecoder dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .instruction       (instruction),
        .pc                (pc),
        .base_value        (base_value),
        .done              (done),
        .is_branch         (is_branch),
        .is_unconditional  (is_unconditional),
        .is_direct         (is_direct),
        .is_call           (is_call),
        .is_return         (is_return),
        .is_load           (is_load),
        .is_store          (is_store),
        .has_load_delay    (has_load_delay),
        .ends_block        (ends_block),
        .is_valid          (is_valid),
        .branch_target     (branch_target),
        .effective_address (effective_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input beats and result beats, sampled at the edge that takes them
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check('{is_branch, is_unconditional, is_direct, is_call, is_return,
                          is_load, is_store, has_load_delay, ends_block, is_valid,
                          branch_target, effective_address});
        if (rst_n && start && !busy)
            board.note(instruction, pc, base_value);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] rtype(logic [4:0] rs, logic [5:0] fn);
        return {OP_SPECIAL, rs, 5'($urandom), 10'($urandom), fn};
    endfunction

    function automatic logic [5:0] memory_opcode();
        case ($urandom_range(0, 13))
            0: return OP_LB;
            1: return OP_LH;
            2: return OP_LWL;
            3: return OP_LW;
            4: return OP_LBU;
            5: return OP_LHU;
            6: return OP_LWR;
            7: return OP_SB;
            8: return OP_SH;
            9: return OP_SWL;
            10: return OP_SW;
            11: return OP_SWR;
            12: return OP_LWC2;
            default: return OP_SWC2;
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [4:0]  rs;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2, 3, 4, 5: w[31:26] = memory_opcode();
            6:
            begin
                case ($urandom_range(0, 4))
                    0: w[5:0] = FN_JR;
                    1: w[5:0] = FN_JALR;
                    2: w[5:0] = FN_SYSCALL;
                    3: w[5:0] = FN_BREAK;
                    default: ;
                endcase
                w[31:26] = OP_SPECIAL;
                if ($urandom_range(0, 1))
                    w[25:21] = REG_RA;
            end
            7:
            begin
                w[31:26] = 6'($urandom_range(OP_REGIMM, OP_BGTZ));
                if ($urandom_range(0, 2) == 0)
                    w[25:16] = 10'd0;
            end
            8:
            begin
                w[31:26] = $urandom_range(0, 1) ? OP_COP0 : OP_COP2;
                rs = 5'($urandom);
                case ($urandom_range(0, 2))
                    0: rs = COPMV_MF;
                    1: rs = COPMV_CF;
                    default: ;
                endcase
                w[25:21] = rs;
            end
            default: w[31:26] = 6'($urandom_range(0, 63));
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_address();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
            1: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // presents one beat and returns at the edge that takes it
    task automatic send(logic [31:0] word, logic [31:0] pc_in, logic [31:0] base);
        if (!calm && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 5));
        start <= 1'b1;
        instruction <= word;
        pc <= pc_in;
        base_value <= base;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int guard;
        cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        instruction = 32'd0;
        pc = 32'd0;
        base_value = 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send({OP_J, 26'h3FF_FFFF}, 32'hFFFF_FFFC, $urandom);
        send({OP_JAL, 26'h000_0000}, 32'h8FFF_FFFC, $urandom);
        send(itype(OP_BEQ, REG_ZERO, REG_ZERO, 16'h8000), 32'h0000_0000, $urandom);
        send(itype(OP_BEQ, 5'd1, 5'd2, 16'h7FFF), 32'hFFFF_FFF0, $urandom);
        send(itype(OP_BNE, 5'd3, REG_ZERO, 16'hFFFF), 32'h0000_0004, $urandom);
        send(itype(OP_BLEZ, 5'd4, 5'd0, 16'h0001), 32'h1234_5678, $urandom);
        send(itype(OP_BGTZ, 5'd5, 5'd0, 16'hFFFE), 32'h0000_0008, $urandom);
        send(itype(OP_REGIMM, 5'd6, 5'd17, 16'h0010), 32'hBFC0_0000, $urandom);
        send(rtype(REG_RA, FN_JR), $urandom, $urandom);
        send(rtype(REG_RA, FN_JALR), $urandom, $urandom);
        send(rtype(5'd4, FN_JR), $urandom, $urandom);
        send(rtype(5'd5, FN_JALR), $urandom, $urandom);
        send(rtype(5'd0, FN_SYSCALL), $urandom, $urandom);
        send(rtype(5'd0, FN_BREAK), $urandom, $urandom);
        send(rtype(5'd0, FN_UNKNOWN), $urandom, $urandom);
        send(rtype(5'd0, FN_SLL), $urandom, $urandom);
        // address sums near the ends of the range, some wrapping around the top, then cop moves
        send(itype(OP_LB, 5'd1, 5'd2, 16'h0001), $urandom, 32'hFFFF_FFFF);
        send(itype(OP_LH, 5'd1, 5'd2, 16'h8000), $urandom, 32'h0000_0000);
        send(itype(OP_LWL, 5'd1, 5'd2, 16'h0002), $urandom, 32'h0000_0003);
        send(itype(OP_SWR, 5'd1, 5'd2, 16'hFFFF), $urandom, 32'h8000_0001);
        send(itype(OP_LWC2, 5'd1, 5'd2, 16'h7FFF), $urandom, 32'hFFFF_8001);
        send(itype(OP_SWC2, 5'd1, 5'd2, 16'h0004), $urandom, 32'h7FFF_FFFE);
        send(itype(OP_COP0, COPMV_MF, 5'd3, 16'h0000), $urandom, $urandom);
        send(itype(OP_COP2, COPMV_CF, 5'd3, 16'h0000), $urandom, $urandom);
        send(itype(OP_COP0, COPMV_MT, 5'd3, 16'h0000), $urandom, $urandom);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i >= RANDOM_BEATS - CALM_TAIL)
                calm = 1'b1;
            send(random_word(), random_address(), random_address());
        end
        start <= 1'b0;

        guard = 0;
        while (board.pending_decodes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (board.pending_decodes.size() != 0)
        begin
            $error("%0d decodes never arrived", board.pending_decodes.size());
            board.errors++;
        end

        if (board.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== mips1_instruction_predecoder.f =====
+incdir+rtl/core
rtl/core/mipd_pkg.sv
rtl/core/mipd_decode.sv
rtl/core/mipd_addr.sv
rtl/core/mips1_instruction_predecoder.sv
rtl/core/mipd_checker.sv
tb/tb_top.sv
